FILE: rtl/lru_worker_queue_heartbeat_top_macros.svh
// Assertion macros shared by the worker queue RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LRU_WORKER_QUEUE_HEARTBEAT_TOP_MACROS_SVH
`define LRU_WORKER_QUEUE_HEARTBEAT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lruq_pkg.sv
// Package for the worker queue: transaction types, codes, reset values and helpers.
// No dependencies; used by every module of the block.
`default_nettype none

package lruq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int ID_BITS_DEF = 16;

	localparam logic [3:0]  LIVENESS_RESET = 4'd3;
	localparam logic [15:0] INTERVAL_RESET = 16'd1000;
	localparam int          TIME_W         = 32;

	localparam logic [1:0] OP_READY   = 2'd0;
	localparam logic [1:0] OP_REQUEST = 2'd1;

	localparam logic REG_LIVENESS = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic [2:0] K_ACCEPTED   = 3'd0;
	localparam logic [2:0] K_DISPATCHED = 3'd1;
	localparam logic [2:0] K_NO_WORKER  = 3'd2;
	localparam logic [2:0] K_FULL       = 3'd3;
	localparam logic [2:0] K_HEARTBEAT  = 3'd4;
	localparam logic [2:0] K_TICK       = 3'd5;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] worker_id;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] target_id;
		logic [4:0]  queued;
		logic        last;
	} result_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lruq_cell.sv
// One queue cell: holds a worker id and its expiry time, loads a new entry or its neighbour's.
// Depends on lruq_pkg.
`default_nettype none

module lruq_cell
	import lruq_pkg::*;
#(
	parameter int IDW = ID_BITS_DEF
) (
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [IDW-1:0]    nbr_id,
	input  wire logic [TIME_W-1:0] nbr_exp,
	input  wire logic [IDW-1:0]    new_id,
	input  wire logic [TIME_W-1:0] new_exp,
	input  wire logic [IDW-1:0]    key,
	output logic [IDW-1:0]         id,
	output logic [TIME_W-1:0]      exp_ms,
	output logic                   hit
);

	logic [IDW-1:0]    id_q;
	logic [TIME_W-1:0] exp_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			id_q  <= new_id;
			exp_q <= new_exp;
		end else if (ctl.shift) begin
			id_q  <= nbr_id;
			exp_q <= nbr_exp;
		end
	end

	assign id     = id_q;
	assign exp_ms = exp_q;
	assign hit    = (id_q == key);

endmodule

`default_nettype wire

FILE: rtl/lruq_chain.sv
// Row of queue cells with the head at cell zero, shift window and tail load decode, and id search.
// Depends on lruq_pkg and lruq_cell.
`default_nettype none

module lruq_chain
	import lruq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDW   = ID_BITS_DEF,
	localparam int IW   = $clog2(DEPTH),
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic [CW-1:0]     count,
	input  wire logic              shift_en,
	input  wire logic [IW-1:0]     shift_from,
	input  wire logic [IW-1:0]     shift_to,
	input  wire logic              load_en,
	input  wire logic [IW-1:0]     load_idx,
	input  wire logic [IDW-1:0]    load_id,
	input  wire logic [TIME_W-1:0] load_exp,
	input  wire logic [IDW-1:0]    key,
	output logic [IDW-1:0]         head_id,
	output logic [TIME_W-1:0]      head_exp,
	output logic [DEPTH-1:0]       hit,
	output logic                   found,
	output logic [IW-1:0]          hit_pos
);

	logic [IDW-1:0]    ids  [DEPTH];
	logic [TIME_W-1:0] exps [DEPTH];
	logic [DEPTH-1:0]  raw_hit;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		localparam logic [IW-1:0] IDX = IW'(j);
		localparam int NB = (j < DEPTH - 1) ? j + 1 : j;
		cell_ctl_t ctl;

		assign ctl.load  = load_en && (load_idx == IDX);
		assign ctl.shift = shift_en && (IDX >= shift_from) && (IDX < shift_to);

		lruq_cell #(.IDW(IDW)) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.nbr_id  (ids[NB]),
			.nbr_exp (exps[NB]),
			.new_id  (load_id),
			.new_exp (load_exp),
			.key     (key),
			.id      (ids[j]),
			.exp_ms  (exps[j]),
			.hit     (raw_hit[j])
		);

		assign hit[j] = raw_hit[j] && (CW'(j) < count);
	end

	always_comb begin
		hit_pos = '0;
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_pos = IW'(j);
			end
		end
	end

	assign found    = |hit;
	assign head_id  = ids[0];
	assign head_exp = exps[0];

endmodule

`default_nettype wire

FILE: rtl/lru_worker_queue_heartbeat_top.sv
// Top level of the least-recently-ready worker queue with heartbeat expiry.
// Depends on lruq_pkg, lruq_chain and the assertion macro header.
//
// Usage: items (opcode, worker id, time) arrive on the item channel under
// item_valid/item_stall; results leave on the result channel under
// result_valid/result_stall, each item giving one primary result followed by a
// heartbeat transaction per queued worker when the heartbeat time has passed.
// The final result of an item carries last. Configuration must be written through
// cfg_wr/cfg_idx/cfg_wdata while the block is idle; the block itself does not enforce this.
// Sequence: a taken item is registered and moves the block to EXEC, where its
// primary result is registered once the output is free. With a heartbeat due,
// BEAT then emits one heartbeat per queued worker, moving each head entry to the
// tail so that the round rotates the queue once, and PURGE shifts expired entries
// out at the head before the next item is taken.
// Reset empties the queue, restores the register defaults and arms the first
// heartbeat at the default interval. While the receiver stalls, the pending
// result is held and the block waits without losing or repeating any result.
`default_nettype none
`include "lru_worker_queue_heartbeat_top_macros.svh"

module lru_worker_queue_heartbeat_top
	import lruq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	input  wire logic        cfg_wr,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_wdata
);

	localparam int IW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int IDW = (ID_BITS < 16) ? ID_BITS : 16;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_BEAT  = 2'd2;
	localparam logic [1:0] ST_PURGE = 2'd3;

	logic [1:0]        state_q, state_nx;
	item_t             item_q;
	logic [CW-1:0]     count_q, count_nx;
	logic [IW-1:0]     beat_q, beat_nx;
	logic [TIME_W-1:0] next_hb_q, hb_nx;
	logic [3:0]        liveness_q;
	logic [15:0]       interval_q;
	logic              res_valid_q;
	result_t           res_q, res_nx;
	logic              emit;

	logic              accept, out_free, purge_hit, beat_last, hb_due;
	logic [IDW-1:0]    key, head_id, ld_id;
	logic [TIME_W-1:0] head_exp, ld_exp, ready_exp;
	logic [19:0]       life_ms;
	localparam int DEPTH_HIT_W = QUEUE_DEPTH;
	logic [DEPTH_HIT_W-1:0] hit;
	logic              found;
	logic [IW-1:0]     hit_pos, last_idx, ld_idx, sh_from, sh_to;
	logic              sh_en, ld_en;
	logic [CW-1:0]     cnt_m1;

	assign key       = item_q.worker_id[IDW-1:0];
	assign out_free  = !res_valid_q || !result_stall;
	assign purge_hit = (count_q != '0) && (item_q.now_ms >= head_exp);
	assign item_stall = !((state_q == ST_IDLE) || ((state_q == ST_PURGE) && !purge_hit));
	assign accept    = item_valid && !item_stall;
	assign cnt_m1    = count_q - CW'(1);
	assign last_idx  = cnt_m1[IW-1:0];
	assign beat_last = (CW'(beat_q) == cnt_m1);
	assign life_ms   = 20'(liveness_q) * 20'(interval_q);
	assign ready_exp = sat_add(item_q.now_ms, TIME_W'(life_ms));
	assign hb_due    = (item_q.now_ms >= next_hb_q);

	lruq_chain #(.DEPTH(QUEUE_DEPTH), .IDW(IDW)) u_chain (
		.clk        (clk),
		.count      (count_q),
		.shift_en   (sh_en),
		.shift_from (sh_from),
		.shift_to   (sh_to),
		.load_en    (ld_en),
		.load_idx   (ld_idx),
		.load_id    (ld_id),
		.load_exp   (ld_exp),
		.key        (key),
		.head_id    (head_id),
		.head_exp   (head_exp),
		.hit        (hit),
		.found      (found),
		.hit_pos    (hit_pos)
	);

	always_comb begin
		state_nx = state_q;
		count_nx = count_q;
		beat_nx  = beat_q;
		hb_nx    = next_hb_q;
		emit     = 1'b0;
		res_nx   = '0;
		sh_en    = 1'b0;
		sh_from  = '0;
		sh_to    = last_idx;
		ld_en    = 1'b0;
		ld_idx   = last_idx;
		ld_id    = key;
		ld_exp   = ready_exp;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					case (item_q.opcode)
						OP_READY: begin
							res_nx.target_id = 16'(key);
							res_nx.kind      = K_ACCEPTED;
							if (found) begin
								sh_en   = 1'b1;
								sh_from = hit_pos;
								ld_en   = 1'b1;
							end else if (count_q == CW'(QUEUE_DEPTH)) begin
								res_nx.kind = K_FULL;
							end else begin
								ld_en    = 1'b1;
								ld_idx   = count_q[IW-1:0];
								count_nx = count_q + CW'(1);
							end
						end
						OP_REQUEST: begin
							if (count_q == '0) begin
								res_nx.kind = K_NO_WORKER;
							end else begin
								res_nx.kind      = K_DISPATCHED;
								res_nx.target_id = 16'(head_id);
								sh_en            = 1'b1;
								count_nx         = cnt_m1;
							end
						end
						default: begin
							res_nx.kind = K_TICK;
						end
					endcase
					res_nx.queued = 5'(count_nx);
					res_nx.last   = !hb_due || (count_nx == '0);
					beat_nx       = '0;
					if (hb_due) begin
						hb_nx = sat_add(item_q.now_ms, TIME_W'(interval_q));
					end
					state_nx = (hb_due && (count_nx != '0)) ? ST_BEAT : ST_PURGE;
				end
			end
			ST_BEAT: begin
				if (out_free) begin
					emit             = 1'b1;
					res_nx.kind      = K_HEARTBEAT;
					res_nx.target_id = 16'(head_id);
					res_nx.queued    = 5'(count_q);
					res_nx.last      = beat_last;
					sh_en            = 1'b1;
					ld_en            = 1'b1;
					ld_id            = head_id;
					ld_exp           = head_exp;
					beat_nx          = beat_q + IW'(1);
					if (beat_last) begin
						state_nx = ST_PURGE;
					end
				end
			end
			ST_PURGE: begin
				if (purge_hit) begin
					sh_en    = 1'b1;
					count_nx = cnt_m1;
				end else if (accept) begin
					state_nx = ST_EXEC;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			beat_q      <= '0;
			next_hb_q   <= TIME_W'(INTERVAL_RESET);
			liveness_q  <= LIVENESS_RESET;
			interval_q  <= INTERVAL_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			count_q   <= count_nx;
			beat_q    <= beat_nx;
			next_hb_q <= hb_nx;
			if (cfg_wr) begin
				case (cfg_idx)
					REG_LIVENESS: liveness_q <= cfg_wdata[3:0];
					REG_INTERVAL: interval_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (emit) begin
			res_q <= res_nx;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`LRUQ_ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "queue count beyond depth")
	`LRUQ_ASSERT_IMPLY(a_beat_bound, clk, arst_n, state_q == ST_BEAT, CW'(beat_q) < count_q, "heartbeat round overruns the queue")
	`LRUQ_ASSERT_NEXT(a_beat_end, clk, arst_n, (state_q == ST_BEAT) && emit && beat_last, state_q == ST_PURGE, "heartbeat round did not end in purge")
	`LRUQ_ASSERT_IMPLY(a_unique_id, clk, arst_n, state_q == ST_EXEC, $onehot0(hit), "worker id queued more than once")

endmodule

`default_nettype wire
